@@ rtl/lpdr_pkg.sv @@
// shared types and constants of the literal pair dense relabel core
package lpdr_pkg;

  localparam int unsigned LIT_W = 17;
  localparam int unsigned NEW_W = 18;
  localparam int unsigned LAB_W = 17;

  localparam int unsigned VAR_COUNT_DEF = 65536;
  // largest magnitude a 17-bit literal can carry is 65536, so no more entries are ever used
  localparam int unsigned MAG_LIMIT = 65537;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_WAIT
  } state_e;

endpackage

@@ rtl/literal_pair_dense_relabel_core.sv @@
// literal pair dense relabel core: first occurrence label table in one synchronous memory
// a clause passes LOOK_A and LOOK_B; its result is registered when the output is free
// two read-modify-writes on the table port per clause; the next waits for LOOK_B or WAIT
// reset: the table is swept to zero one entry a cycle, min(VAR_COUNT, 65537) entries
// (65536 by default), while the input stays stalled; next label restarts at one
module literal_pair_dense_relabel_core #(
  parameter int unsigned VAR_COUNT = lpdr_pkg::VAR_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lpdr_pkg::LIT_W-1:0]   lit_a_i,
  input  logic signed [lpdr_pkg::LIT_W-1:0]   lit_b_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lpdr_pkg::NEW_W-1:0]   new_a_o,
  output logic signed [lpdr_pkg::NEW_W-1:0]   new_b_o,
  output logic        [lpdr_pkg::LAB_W-1:0]   labels_used_o
);

  // only magnitudes up to 65536 ever reach the table
  localparam int unsigned Depth =
    (VAR_COUNT < lpdr_pkg::MAG_LIMIT) ? VAR_COUNT : lpdr_pkg::MAG_LIMIT;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned LitW = lpdr_pkg::LIT_W;
  localparam int unsigned NewW = lpdr_pkg::NEW_W;
  localparam int unsigned LabW = lpdr_pkg::LAB_W;
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  // magnitude of a two's complement literal; the most negative value gives 65536
  function automatic logic [LitW-1:0] mag_of(input logic [LitW-1:0] lit);
    return lit[LitW-1] ? (~lit + LitW'(1)) : lit;
  endfunction

  function automatic logic in_table(input logic [LitW-1:0] mag);
    return ({{(32 - LitW){1'b0}}, mag} < 32'(Depth));
  endfunction

  // label with the literal's sign put back
  function automatic logic [NewW-1:0] signed_label(input logic neg,
                                                   input logic [LabW-1:0] lab);
    logic [NewW-1:0] ext;
    ext = {{(NewW - LabW){1'b0}}, lab};
    return neg ? (~ext + NewW'(1)) : ext;
  endfunction

  lpdr_pkg::state_e state_q, state_d;

  // label table, one read and one write port, registered read data
  logic [LabW-1:0] label_mem_q [Depth];
  logic [LabW-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [LabW-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;

  // bypass for a write landing on the entry read in the same cycle
  logic            fwd_hit_q;
  logic [LabW-1:0] fwd_data_q;
  logic [LabW-1:0] rd_eff;

  logic [AW-1:0]   clr_q;
  logic [LabW-1:0] next_label_q, next_label_d;

  // captured clause
  logic [AW-1:0]   idx_a_q, idx_b_q;
  logic            neg_a_q, neg_b_q;
  logic            oor_a_q, oor_b_q;
  logic [LabW-1:0] lab_a_q, lab_b_q;
  logic [LabW-1:0] lab_new;

  logic [LitW-1:0] mag_a_in, mag_b_in;

  logic                   out_valid_q;
  logic signed [NewW-1:0] new_a_q, new_b_q;
  logic [LabW-1:0]        used_q;

  logic out_free;
  logic in_accept;
  logic load_out;
  logic [LabW-1:0] res_lab_b;

  assign mag_a_in = mag_of(lit_a_i);
  assign mag_b_in = mag_of(lit_b_i);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign rd_eff    = fwd_hit_q ? fwd_data_q : rdata_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpdr_pkg::ST_CLEAR: begin
        if (clr_q == LastIdx) state_d = lpdr_pkg::ST_IDLE;
      end
      lpdr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lpdr_pkg::ST_LOOK_A;
      end
      lpdr_pkg::ST_LOOK_A: begin
        state_d = lpdr_pkg::ST_LOOK_B;
      end
      lpdr_pkg::ST_LOOK_B, lpdr_pkg::ST_WAIT: begin
        if (out_free) begin
          state_d = in_valid_i ? lpdr_pkg::ST_LOOK_A : lpdr_pkg::ST_IDLE;
        end else begin
          state_d = lpdr_pkg::ST_WAIT;
        end
      end
      default: state_d = lpdr_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer: handshake, table port, label counter
  always_comb begin
    in_stall_o   = 1'b1;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_a_q;
    mem_wdata    = next_label_q;
    mem_raddr    = mag_a_in[AW-1:0];
    next_label_d = next_label_q;
    lab_new      = lab_b_q;
    case (state_q)
      lpdr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      lpdr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      lpdr_pkg::ST_LOOK_A: begin
        // first literal: take the stored label or hand out the next one
        mem_raddr = idx_b_q;
        mem_waddr = idx_a_q;
        if (oor_a_q) begin
          lab_new = '0;
        end else if (rd_eff == '0) begin
          lab_new      = next_label_q;
          mem_we       = 1'b1;
          next_label_d = next_label_q + LabW'(1);
        end else begin
          lab_new = rd_eff;
        end
      end
      lpdr_pkg::ST_LOOK_B: begin
        // second literal; a repeat of the first sees its fresh label through the bypass
        in_stall_o = !out_free;
        load_out   = out_free;
        mem_waddr  = idx_b_q;
        if (oor_b_q) begin
          lab_new = '0;
        end else if (rd_eff == '0) begin
          lab_new      = next_label_q;
          mem_we       = 1'b1;
          next_label_d = next_label_q + LabW'(1);
        end else begin
          lab_new = rd_eff;
        end
      end
      lpdr_pkg::ST_WAIT: begin
        in_stall_o = !out_free;
        load_out   = out_free;
      end
      default: ;
    endcase
  end

  assign res_lab_b = (state_q == lpdr_pkg::ST_LOOK_B) ? lab_new : lab_b_q;

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) label_mem_q[mem_waddr] <= mem_wdata;
    rdata_q    <= label_mem_q[mem_raddr];
    fwd_data_q <= mem_wdata;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lpdr_pkg::ST_CLEAR;
      clr_q        <= '0;
      next_label_q <= LabW'(1);
      out_valid_q  <= 1'b0;
      fwd_hit_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_label_q <= next_label_d;
      fwd_hit_q    <= mem_we && (mem_waddr == mem_raddr);
      if (state_q == lpdr_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // clause capture, labels and result transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      idx_a_q <= mag_a_in[AW-1:0];
      idx_b_q <= mag_b_in[AW-1:0];
      neg_a_q <= lit_a_i[LitW-1];
      neg_b_q <= lit_b_i[LitW-1];
      oor_a_q <= !in_table(mag_a_in);
      oor_b_q <= !in_table(mag_b_in);
    end
    if (state_q == lpdr_pkg::ST_LOOK_A) lab_a_q <= lab_new;
    if (state_q == lpdr_pkg::ST_LOOK_B) lab_b_q <= lab_new;
    if (load_out) begin
      new_a_q <= $signed(signed_label(neg_a_q, lab_a_q));
      new_b_q <= $signed(signed_label(neg_b_q, res_lab_b));
      used_q  <= next_label_d - LabW'(1);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_a_o       = new_a_q;
  assign new_b_o       = new_b_q;
  assign labels_used_o = used_q;

endmodule

@@ tb/literal_pair_dense_relabel_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the literal pair dense relabel core
module literal_pair_dense_relabel_core_tb;

  localparam int unsigned LIT_W      = lpdr_pkg::LIT_W;
  localparam int unsigned NEW_W      = lpdr_pkg::NEW_W;
  localparam int unsigned LAB_W      = lpdr_pkg::LAB_W;
  localparam int unsigned VAR_COUNT  = lpdr_pkg::VAR_COUNT_DEF;
  localparam int          RAND_ITEMS = 1750;
  // the reset sweep of the whole table is one long idle stretch, so allow several times it
  localparam int          WDOG_LIMIT = 4 * 65537 + 2000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct {
    logic signed [LIT_W-1:0] lit_a;
    logic signed [LIT_W-1:0] lit_b;
  } clause_t;

  typedef struct {
    logic signed [NEW_W-1:0] new_a;
    logic signed [NEW_W-1:0] new_b;
    logic        [LAB_W-1:0] labels_used;
  } renamed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LIT_W-1:0] lit_a = '0;
  logic signed [LIT_W-1:0] lit_b = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [NEW_W-1:0] new_a;
  logic signed [NEW_W-1:0] new_b;
  logic        [LAB_W-1:0] labels_used;

  // predictor state: label per variable number, zero while unlabeled
  logic [LAB_W-1:0] label_of [0:VAR_COUNT-1];
  logic [LAB_W-1:0] next_label;

  clause_t  pending_clauses[$];
  renamed_t expected_renames[$];

  int total_clauses = 0;
  int clauses_taken = 0;
  int renames_seen  = 0;
  int mismatch_cnt  = 0;
  int outside_cnt   = 0;
  int idle_cycles   = 0;
  int in_gap        = 0;
  int stall_gap     = 0;
  bit in_hold       = 1'b0;
  bit hold_off      = 1'b0;
  bit calm;

  literal_pair_dense_relabel_core #(
    .VAR_COUNT(VAR_COUNT)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .lit_a_i      (lit_a),
    .lit_b_i      (lit_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .new_a_o      (new_a),
    .new_b_o      (new_b),
    .labels_used_o(labels_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rename one literal, labeling its variable on first sight
  function automatic logic signed [NEW_W-1:0] rename_literal(logic signed [LIT_W-1:0] lit);
    int                      mag;
    logic                    neg;
    logic signed [NEW_W-1:0] renamed;
    neg = (lit < 0);
    mag = neg ? -int'(lit) : int'(lit);
    // magnitude past the table gets no label at all
    if (mag >= int'(VAR_COUNT)) begin
      outside_cnt++;
      return '0;
    end
    if (label_of[mag] == '0) begin
      label_of[mag] = next_label;
      next_label    = next_label + 1'b1;
    end
    renamed = {1'b0, label_of[mag]};
    if (neg) begin
      renamed = -renamed;
    end
    return renamed;
  endfunction

  // random literal: mostly a small variable pool so labels get reused
  function automatic logic signed [LIT_W-1:0] pick_literal();
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      mag = $urandom_range(0, 63);
    end else if (r < 65) begin
      mag = $urandom_range(65500, 65536);
    end else if (r < 70) begin
      mag = 65536;
    end else begin
      mag = $urandom_range(0, 65536);
    end
    // only the negative side can carry magnitude 65536
    if (mag == 65536 || $urandom_range(0, 1) == 1) begin
      return LIT_W'(-mag);
    end
    return LIT_W'(mag);
  endfunction

  task automatic add_clause(logic signed [LIT_W-1:0] a, logic signed [LIT_W-1:0] b);
    clause_t c;
    c.lit_a = a;
    c.lit_b = b;
    pending_clauses.push_back(c);
    total_clauses++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // no idling in every third window of 200 clauses and in the last stretch of the run
  assign calm = ((clauses_taken / 200) % 3 == 2) || (clauses_taken >= total_clauses - 250);

  // acceptance on the input side: predict the result of each clause taken
  always @(posedge clk) begin
    renamed_t exp_r;
    if (rst_n && in_valid && !in_stall) begin
      exp_r.new_a       = rename_literal(pending_clauses[0].lit_a);
      exp_r.new_b       = rename_literal(pending_clauses[0].lit_b);
      exp_r.labels_used = next_label - 1'b1;
      expected_renames.push_back(exp_r);
      void'(pending_clauses.pop_front());
      in_hold = 1'b0;
      clauses_taken++;
    end
  end

  // driver: offers the next pending clause, with random idle bursts
  always @(negedge clk) begin
    if (rst_n && !in_hold) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_clauses.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else begin
          lit_a    <= pending_clauses[0].lit_a;
          lit_b    <= pending_clauses[0].lit_b;
          in_valid <= 1'b1;
          in_hold  = 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts plus the long hold-off
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_gap = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: every accepted result against the oldest prediction
  always @(posedge clk) begin
    renamed_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      renames_seen++;
      if (expected_renames.size() == 0) begin
        report_mismatch("result transaction with no clause outstanding", renames_seen,
                        clauses_taken);
      end else begin
        exp_r = expected_renames.pop_front();
        if (new_a !== exp_r.new_a) begin
          report_mismatch("new_a", int'(new_a), int'(exp_r.new_a));
        end
        if (new_b !== exp_r.new_b) begin
          report_mismatch("new_b", int'(new_b), int'(exp_r.new_b));
        end
        if (labels_used !== exp_r.labels_used) begin
          report_mismatch("labels_used", int'(labels_used), int'(exp_r.labels_used));
        end
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("[%0t] timeout, %0d of %0d clauses taken, %0d results outstanding",
                 $time, clauses_taken, total_clauses, expected_renames.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // long receiver hold-off while the driver keeps offering, so the core backs up
  initial begin
    wait (clauses_taken >= 300);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    for (int i = 0; i < int'(VAR_COUNT); i++) begin
      label_of[i] = '0;
    end
    next_label = 1;

    // literal zero is an ordinary positive variable
    add_clause(0, 0);
    add_clause(1, -1);
    // most negative literal lies past the table, first and second position
    add_clause(-65536, 5);
    add_clause(0, -65536);
    add_clause(-65536, -65536);
    // table edges
    add_clause(65535, -65535);
    add_clause(65535, 65535);
    // same variable twice in one clause gets one label
    add_clause(7, 7);
    add_clause(-9, 9);
    // first appearance negated
    add_clause(-2, 3);
    add_clause(-1, 2);
    add_clause(-32768, 32767);
    add_clause(21845, -21846);
    add_clause(-21845, 21846);
    add_clause(65534, -65534);
    add_clause(16, -65535);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      add_clause(pick_literal(), pick_literal());
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (clauses_taken == total_clauses);
    wait (renames_seen >= clauses_taken);
    repeat (20) @(posedge clk);

    $display("covered %0d clauses (16 directed), %0d labels handed out,", total_clauses,
             int'(next_label) - 1);
    $display("%0d literals outside the table, %0d results checked", outside_cnt, renames_seen);
    if (mismatch_cnt == 0 && expected_renames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
